// ===== src/pdne_pkg.sv =====
// Package for the pedal debounce and note event block.
// Holds the field widths, register indexes and the packed word types shared by the modules.
// Depends on nothing.
`default_nettype none

package pdne_pkg;

	localparam int MAX_PEDALS  = 32;
	localparam int TIME_W      = 32;
	localparam int LEVEL_W     = 32;
	localparam int ROOM_W      = 6;
	localparam int NUM_W       = 5;
	localparam int COUNT_W     = 6;
	localparam int TOG_W       = 16;
	localparam int DEB_W       = 8;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 32;
	localparam int QUEUE_DEPTH = 2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE   = 1'b1;

	// One scan tick.
	typedef struct packed {
		logic [TIME_W-1:0]  now_ms;
		logic [LEVEL_W-1:0] pedal_levels;
		logic [ROOM_W-1:0]  note_room;
	} tick_t;

	// One result word.
	typedef struct packed {
		logic               note_valid;
		logic [NUM_W-1:0]   note_number;
		logic               note_on;
		logic [COUNT_W-1:0] pressed_count;
		logic [TOG_W-1:0]   pedal_toggles;
		logic [TOG_W-1:0]   note_toggles;
		logic               last;
	} note_evt_t;

	// Snapshot of a debounced tick, passed from the front to the back.
	typedef struct packed {
		logic [MAX_PEDALS-1:0] accepted;
		logic [COUNT_W-1:0]    pressed_count;
		logic [TOG_W-1:0]      pedal_toggles;
		logic [ROOM_W-1:0]     note_room;
	} tick_rec_t;

endpackage

`default_nettype wire

// ===== src/pedal_debounce_note_events.sv =====
// A tick is taken in F_IDLE, debounced in F_RUN one pedal a cycle (one change-time
// subtract and compare each) and pushed to the queue from F_PUSH, which waits while the
// queue is full. The front takes no new tick until that push is done; the back end gives
// one result word per cycle while its queue is not empty and the receiver is ready.
// Reset (arst_n low, asynchronous) clears all pedal, note and counter state, both
// configuration registers and the queue; change times are written before they matter.
`default_nettype none

module pedal_debounce_note_events #(
	parameter int NUM_PEDALS = pdne_pkg::MAX_PEDALS
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               cfg_we,
	input  wire  [pdne_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire  [pdne_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  wire                               tick_valid,
	output logic                              tick_ready,
	input  pdne_pkg::tick_t                   tick,
	output logic                              evt_valid,
	input  wire                               evt_ready,
	output pdne_pkg::note_evt_t               evt
);
	import pdne_pkg::*;

	// The front end owns the debounce state: tentative level, change time and accepted
	// state per pedal, plus the pedal toggle counter and the running pressed count. Once
	// it has walked every pedal it pushes a snapshot of the accepted state and counters.
	logic       push;
	logic       full;
	logic       pop;
	logic       empty;
	tick_rec_t  rec_in;
	tick_rec_t  rec_out;

	pdne_front #(
		.NUM_PEDALS (NUM_PEDALS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.tick_valid (tick_valid),
		.tick_ready (tick_ready),
		.tick       (tick),
		.push       (push),
		.rec        (rec_in),
		.full       (full)
	);

	// The queue lets the front debounce the next tick while the back is still
	// emitting notes for this one, or while the result word is held up downstream.
	pdne_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.rec_in  (rec_in),
		.full    (full),
		.pop     (pop),
		.rec_out (rec_out),
		.empty   (empty)
	);

	// The back end compares each snapshot against the played state and emits notes in
	// pedal order until the room runs out; a tick with nothing to play gives a single
	// status word. Pedals left over stay pending for a later tick.
	pdne_back #(
		.NUM_PEDALS (NUM_PEDALS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rec       (rec_out),
		.empty     (empty),
		.pop       (pop),
		.evt_valid (evt_valid),
		.evt_ready (evt_ready),
		.evt       (evt)
	);

endmodule

`default_nettype wire

// ===== src/pdne_front.sv =====
// Debounce front end: takes a scan tick, walks the pedals one per cycle and pushes a snapshot.
// Also holds the two configuration registers.
// Depends on pdne_pkg.
`default_nettype none

module pdne_front #(
	parameter int NUM_PEDALS = pdne_pkg::MAX_PEDALS
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                cfg_we,
	input  wire  [pdne_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire  [pdne_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input  wire                                tick_valid,
	output logic                               tick_ready,
	input  pdne_pkg::tick_t                    tick,
	output logic                               push,
	output pdne_pkg::tick_rec_t                rec,
	input  wire                                full
);
	import pdne_pkg::*;

	localparam int IDX_W = (NUM_PEDALS > 1) ? $clog2(NUM_PEDALS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_PEDALS - 1);

	typedef enum logic [2:0] {
		F_IDLE = 3'b001,
		F_RUN  = 3'b010,
		F_PUSH = 3'b100
	} front_state_t;

	front_state_t              state_q;
	logic [IDX_W-1:0]          idx_q;
	logic [TIME_W-1:0]         now_q;
	logic [NUM_PEDALS-1:0]     press_q;
	logic [ROOM_W-1:0]         room_q;
	logic [DEB_W-1:0]          deb_q;
	logic [NUM_PEDALS-1:0]     en_q;
	logic [NUM_PEDALS-1:0]     tent_q;
	logic [NUM_PEDALS-1:0]     acc_q;
	logic [TIME_W-1:0]         ct_q [NUM_PEDALS];
	logic [TIME_W-1:0]         ct_rd_q;
	logic [TOG_W-1:0]          ptog_q;
	logic [COUNT_W-1:0]        pcnt_q;

	logic                      p;
	logic                      tent_diff;
	logic [TIME_W-1:0]         ct_eff;
	logic [TIME_W-1:0]         elapsed;
	logic                      mature;
	logic                      upd_tent;
	logic                      flip;
	logic                      run;
	logic [IDX_W-1:0]          ct_raddr;

	assign run       = (state_q == F_RUN);
	assign p         = press_q[idx_q];
	assign tent_diff = (tent_q[idx_q] != p);
	assign ct_eff    = tent_diff ? now_q : ct_rd_q;
	assign elapsed   = now_q - ct_eff;
	assign mature    = (elapsed >= {{(TIME_W - DEB_W){1'b0}}, deb_q});
	assign upd_tent  = run && en_q[idx_q] && tent_diff;
	assign flip      = run && en_q[idx_q] && (acc_q[idx_q] != p) && mature;

	// The change time of the next pedal is fetched into a register in the cycle before its turn.
	assign ct_raddr  = (run && (idx_q != LAST_IDX)) ? idx_q + IDX_W'(1) : '0;

	assign tick_ready        = (state_q == F_IDLE);
	assign push              = (state_q == F_PUSH) && !full;
	assign rec.accepted      = MAX_PEDALS'(acc_q);
	assign rec.pressed_count = pcnt_q;
	assign rec.pedal_toggles = ptog_q;
	assign rec.note_room     = room_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deb_q <= '0;
			en_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DEBOUNCE: deb_q <= cfg_wdata[DEB_W-1:0];
				REG_ENABLE:   en_q  <= cfg_wdata[NUM_PEDALS-1:0];
				default:      ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			idx_q   <= '0;
			tent_q  <= '0;
			acc_q   <= '0;
			ptog_q  <= '0;
			pcnt_q  <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					idx_q <= '0;
					if (tick_valid) begin
						state_q <= F_RUN;
					end
				end
				F_RUN: begin
					if (upd_tent) begin
						tent_q[idx_q] <= p;
					end
					if (flip) begin
						acc_q[idx_q] <= p;
						ptog_q       <= ptog_q + TOG_W'(1);
						pcnt_q       <= p ? pcnt_q + COUNT_W'(1) : pcnt_q - COUNT_W'(1);
					end
					if (idx_q == LAST_IDX) begin
						state_q <= F_PUSH;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				F_PUSH: begin
					if (!full) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// Tick payload and change times carry no reset.
	always_ff @(posedge clk) begin
		if (tick_valid && tick_ready) begin
			now_q   <= tick.now_ms;
			press_q <= ~tick.pedal_levels[NUM_PEDALS-1:0];
			room_q  <= tick.note_room;
		end
		if (upd_tent) begin
			ct_q[idx_q] <= now_q;
		end
		ct_rd_q <= ct_q[ct_raddr];
	end

endmodule

`default_nettype wire

// ===== src/pdne_queue.sv =====
// Short queue of debounced tick snapshots between the front and the back.
// Depends on pdne_pkg.
`default_nettype none

module pdne_queue (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push,
	input  pdne_pkg::tick_rec_t  rec_in,
	output logic                 full,
	input  wire                  pop,
	output pdne_pkg::tick_rec_t  rec_out,
	output logic                 empty
);
	import pdne_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	tick_rec_t          mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_q;
	logic [PTR_W-1:0]   rd_q;
	logic [CNT_W-1:0]   cnt_q;

	assign full    = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign empty   = (cnt_q == '0);
	assign rec_out = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= rec_in;
		end
	end

endmodule

`default_nettype wire

// ===== src/pdne_back.sv =====
// Note back end: walks pending pedals of the head snapshot, one result word a cycle if ready.
// Owns the played state and the note toggle counter. Depends on pdne_pkg.
`default_nettype none

module pdne_back #(
	parameter int NUM_PEDALS = pdne_pkg::MAX_PEDALS
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  pdne_pkg::tick_rec_t  rec,
	input  wire                  empty,
	output logic                 pop,
	output logic                 evt_valid,
	input  wire                  evt_ready,
	output pdne_pkg::note_evt_t  evt
);
	import pdne_pkg::*;

	localparam int IDX_W = (NUM_PEDALS > 1) ? $clog2(NUM_PEDALS) : 1;

	logic [NUM_PEDALS-1:0]  play_q;
	logic [ROOM_W-1:0]      sent_q;
	logic [TOG_W-1:0]       ntog_q;
	logic                   ov_q;
	note_evt_t              evt_q;

	logic [NUM_PEDALS-1:0]  pending;
	logic [NUM_PEDALS-1:0]  lowbit;
	logic [NUM_PEDALS-1:0]  rest;
	logic [IDX_W-1:0]       idx;
	logic [ROOM_W-1:0]      sent_next;
	logic                   can_emit;
	logic                   is_last;
	logic                   load;
	note_evt_t              res;

	assign pending   = rec.accepted[NUM_PEDALS-1:0] ^ play_q;
	assign lowbit    = pending & (~pending + NUM_PEDALS'(1));
	assign rest      = pending & ~lowbit;
	assign sent_next = sent_q + ROOM_W'(1);
	assign can_emit  = (pending != '0) && (sent_q < rec.note_room);
	assign is_last   = !can_emit || (sent_next == rec.note_room) || (rest == '0);
	assign load      = !empty && (!ov_q || evt_ready);
	assign pop       = load && is_last;

	always_comb begin
		idx = '0;
		for (int i = 0; i < NUM_PEDALS; i++) begin
			if (lowbit[i]) begin
				idx = IDX_W'(i);
			end
		end
	end

	always_comb begin
		res.note_valid    = can_emit;
		res.note_number   = can_emit ? NUM_W'(idx) : '0;
		res.note_on       = can_emit && rec.accepted[idx];
		res.pressed_count = rec.pressed_count;
		res.pedal_toggles = rec.pedal_toggles;
		res.note_toggles  = can_emit ? ntog_q + TOG_W'(1) : ntog_q;
		res.last          = is_last;
	end

	assign evt_valid = ov_q;
	assign evt       = evt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			play_q <= '0;
			sent_q <= '0;
			ntog_q <= '0;
			ov_q   <= 1'b0;
		end else begin
			if (load) begin
				ov_q <= 1'b1;
				if (can_emit) begin
					play_q <= play_q ^ lowbit;
					ntog_q <= ntog_q + TOG_W'(1);
				end
				sent_q <= is_last ? '0 : sent_next;
			end else if (evt_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			evt_q <= res;
		end
	end

endmodule

`default_nettype wire

// ===== src/pdne_checker.sv =====
// Port-level checks for the pedal debounce block, bound to the top level.
// Depends on pdne_pkg and pedal_debounce_note_events.
`default_nettype none

module pdne_checker #(
	parameter int NUM_PEDALS = pdne_pkg::MAX_PEDALS
) (
	input wire                  clk,
	input wire                  arst_n,
	input wire                  tick_valid,
	input wire                  tick_ready,
	input wire                  evt_valid,
	input wire                  evt_ready,
	input pdne_pkg::note_evt_t  evt
);
	import pdne_pkg::*;

	a_evt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && !evt_ready |=> evt_valid && $stable(evt))
		else $error("result word changed while stalled");

	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		tick_valid && tick_ready |=> !tick_ready)
		else $error("tick taken while debounce was still running");

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && !evt.note_valid |-> evt.last && evt.note_number == '0 && !evt.note_on)
		else $error("status word not alone or not clean");

	a_note_range: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && evt.note_valid |-> 32'(evt.note_number) < NUM_PEDALS)
		else $error("note for a pedal beyond the configured count");

endmodule

bind pedal_debounce_note_events pdne_checker #(
	.NUM_PEDALS (NUM_PEDALS)
) u_pdne_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.tick_valid (tick_valid),
	.tick_ready (tick_ready),
	.evt_valid  (evt_valid),
	.evt_ready  (evt_ready),
	.evt        (evt)
);

`default_nettype wire

// ===== sim/pedal_debounce_note_events_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for pedal_debounce_note_events: scan ticks in, note event words out.
// Depends on pdne_pkg for the word types and register indexes, and on the block's RTL.

module pedal_debounce_note_events_tb;
	import pdne_pkg::*;

	localparam int CLK_PERIOD      = 4;
	localparam int RESET_CYCLES    = 11;
	// A tick is debounced one pedal at a time, so this margin covers anything still moving
	// through the block once the queues are empty.
	localparam int DRAIN_TAIL      = MAX_PEDALS + 8;
	localparam int HOLD_OFF_CYCLES = 500;
	localparam int LIMIT_CYCLES    = 2000000;

	// Block ports. Every input starts at a known value.
	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  tick_valid = 1'b0;
	logic                  tick_ready;
	tick_t                 tick = '0;
	logic                  evt_valid;
	logic                  evt_ready = 1'b0;
	note_evt_t             evt;

	// Ticks waiting to be offered, and the note event words still owed by the block.
	tick_t     pending_ticks[$];
	note_evt_t expected_notes[$];
	note_evt_t want;

	// Percentages of cycles in which each side idles; changed between phases.
	int send_idle_pct = 6;
	int recv_idle_pct = 80;

	bit tick_taken       = 1'b0;
	bit hold_off_request = 1'b0;
	bit recv_stalled     = 1'b0;
	int mismatches       = 0;

	// Running scan state from which the random ticks are built.
	logic [TIME_W-1:0]  scan_ms     = '0;
	logic [LEVEL_W-1:0] scan_levels = '1;
	logic [LEVEL_W-1:0] last_flips  = '0;

	// Our own copy of the block's registers and pedal state, kept in step with every
	// register write and every accepted tick.
	logic [DEB_W-1:0]      cfg_debounce = '0;
	logic [MAX_PEDALS-1:0] cfg_enable   = '0;
	logic [MAX_PEDALS-1:0] tentative    = '0;
	logic [MAX_PEDALS-1:0] accepted     = '0;
	logic [MAX_PEDALS-1:0] playing      = '0;
	logic [TIME_W-1:0]     change_ms [MAX_PEDALS];
	logic [TOG_W-1:0]      pedal_flips  = '0;
	logic [TOG_W-1:0]      note_flips   = '0;

	pedal_debounce_note_events dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.tick_valid (tick_valid),
		.tick_ready (tick_ready),
		.tick       (tick),
		.evt_valid  (evt_valid),
		.evt_ready  (evt_ready),
		.evt        (evt)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Debounces one scan tick and appends the note event words it should produce.
	// Enabled pedals follow their raw level into the tentative state, restarting the
	// timer on each change; a tentative level that has held for the debounce time
	// (wrapping 32-bit difference) becomes the accepted state. Then every pedal whose
	// accepted state differs from what is playing sends a note, in index order, until
	// the room for this tick is used up. A tick that sends nothing still gives one
	// status word.
	function automatic void debounce_and_emit(input tick_t t);
		logic [MAX_PEDALS-1:0] pressed_now;
		logic [TIME_W-1:0]     held_ms;
		logic [COUNT_W-1:0]    pcount;
		int unsigned           room;
		int unsigned           emitted;
		note_evt_t             w;
		pressed_now = ~t.pedal_levels;
		room = t.note_room;
		emitted = 0;
		for (int i = 0; i < MAX_PEDALS; i++) begin
			if (!cfg_enable[i])
				continue;
			if (tentative[i] != pressed_now[i]) begin
				tentative[i] = pressed_now[i];
				change_ms[i] = t.now_ms;
			end
			held_ms = t.now_ms - change_ms[i];
			if (accepted[i] != pressed_now[i] && held_ms >= TIME_W'(cfg_debounce)) begin
				accepted[i] = pressed_now[i];
				pedal_flips = pedal_flips + TOG_W'(1);
			end
		end
		pcount = COUNT_W'($countones(accepted));
		for (int i = 0; i < MAX_PEDALS && emitted < room; i++) begin
			if (accepted[i] == playing[i])
				continue;
			playing[i] = accepted[i];
			note_flips = note_flips + TOG_W'(1);
			w.note_valid    = 1'b1;
			w.note_number   = NUM_W'(i);
			w.note_on       = accepted[i];
			w.pressed_count = pcount;
			w.pedal_toggles = pedal_flips;
			w.note_toggles  = note_flips;
			w.last          = 1'b0;
			expected_notes.push_back(w);
			emitted++;
		end
		if (emitted == 0) begin
			w = '0;
			w.pressed_count = pcount;
			w.pedal_toggles = pedal_flips;
			w.note_toggles  = note_flips;
			w.last          = 1'b1;
		end else begin
			// The final note of the tick closes it.
			w = expected_notes.pop_back();
			w.last = 1'b1;
		end
		expected_notes.push_back(w);
	endfunction

	task automatic check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			mismatches++;
		end
	endtask

	task automatic add_tick(input logic [TIME_W-1:0] now, input logic [LEVEL_W-1:0] levels,
			input logic [ROOM_W-1:0] room);
		tick_t t;
		t.now_ms       = now;
		t.pedal_levels = levels;
		t.note_room    = room;
		scan_ms        = now;
		scan_levels    = levels;
		pending_ticks.push_back(t);
	endtask

	// Registers are only written with the block idle, so the copy in the predictor can be
	// updated at once. The debounce register keeps only its low byte.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_DEBOUNCE: begin
				cfg_debounce = data[DEB_W-1:0];
			end
			REG_ENABLE: begin
				cfg_enable = data;
			end
			default: begin
			end
		endcase
		@(posedge clk);
	endtask

	// Waits until every queued tick has been taken and every owed word has arrived,
	// then lets the block settle. No new ticks are queued for the whole wait.
	task automatic wait_idle();
		do
			@(posedge clk);
		while (pending_ticks.size() != 0 || tick_valid || expected_notes.size() != 0);
		repeat (DRAIN_TAIL) @(posedge clk);
	endtask

	// Random ticks built from the running scan state. Time mostly creeps forward in steps
	// scaled to the debounce time so that levels get the chance to settle, with the odd
	// jump anywhere on the clock. Most ticks keep the levels; some flip a single pedal,
	// some undo the previous flip as a bounce would, and a few flip many pedals at once.
	task automatic queue_random_ticks(input int count);
		int unsigned        span;
		int unsigned        pick;
		logic [LEVEL_W-1:0] flips;
		logic [ROOM_W-1:0]  room;
		logic [TIME_W-1:0]  now;
		for (int k = 0; k < count; k++) begin
			span = cfg_debounce / 6 + 2;
			pick = $urandom_range(99);
			if (pick < 3)
				now = $urandom;
			else
				now = scan_ms + $urandom_range(span);
			pick = $urandom_range(99);
			flips = '0;
			if (pick < 20)
				flips = 32'd1 << $urandom_range(MAX_PEDALS - 1);
			else if (pick < 26)
				flips = last_flips;
			else if (pick < 32)
				flips = $urandom & $urandom;
			else if (pick < 35)
				flips = $urandom;
			if (flips != '0)
				last_flips = flips;
			pick = $urandom_range(99);
			if (pick < 45)
				room = ROOM_W'($urandom_range(MAX_PEDALS));
			else if (pick < 65)
				room = ROOM_W'($urandom_range(2));
			else if (pick < 88)
				room = ROOM_W'(MAX_PEDALS);
			else
				room = ROOM_W'($urandom_range(63, MAX_PEDALS + 1));
			add_tick(now, scan_levels ^ flips, room);
		end
	endtask

	// Sender: a new tick is put out at the falling edge once the previous one has been
	// taken, unless this cycle is chosen to idle. An offered tick is held until taken.
	always @(negedge clk) begin
		if (!arst_n) begin
			tick_valid <= 1'b0;
		end else if (!tick_valid || tick_taken) begin
			if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				tick       <= pending_ticks.pop_front();
				tick_valid <= 1'b1;
			end else begin
				tick_valid <= 1'b0;
			end
		end
	end

	// Receiver: ready drops at random, and for the whole of a long hold-off.
	always @(negedge clk) begin
		evt_ready <= !recv_stalled && ($urandom_range(99) >= recv_idle_pct);
	end

	// The long hold-off counts its own cycles so that the sender keeps offering ticks
	// meanwhile, filling the block until it refuses further input.
	always begin
		wait (hold_off_request);
		recv_stalled = 1'b1;
		repeat (HOLD_OFF_CYCLES) @(posedge clk);
		recv_stalled     = 1'b0;
		hold_off_request = 1'b0;
	end

	// Both handshakes are sampled at the rising edge. A taken tick is predicted first,
	// then any word handed over is compared with the oldest word still owed.
	always @(posedge clk) begin
		tick_taken = arst_n && tick_valid && tick_ready;
		if (tick_taken)
			debounce_and_emit(tick);
		if (arst_n && evt_valid && evt_ready) begin
			if (expected_notes.size() == 0) begin
				$error("note event word with nothing owed: number %0d, last %0d",
					evt.note_number, evt.last);
				mismatches++;
			end else begin
				want = expected_notes.pop_front();
				check_field("note_valid", want.note_valid, evt.note_valid);
				check_field("note_number", want.note_number, evt.note_number);
				check_field("note_on", want.note_on, evt.note_on);
				check_field("pressed_count", want.pressed_count, evt.pressed_count);
				check_field("pedal_toggles", want.pedal_toggles, evt.pedal_toggles);
				check_field("note_toggles", want.note_toggles, evt.note_toggles);
				check_field("last", want.last, evt.last);
			end
		end
	end

	initial begin
		logic [CFG_DATA_W-1:0] deb_word;
		logic [CFG_DATA_W-1:0] en_word;
		int                    seg_len;
		foreach (change_ms[i])
			change_ms[i] = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, with all pedals enabled and a short debounce time.
		write_reg(REG_DEBOUNCE, 32'd3);
		write_reg(REG_ENABLE, 32'hFFFF_FFFF);
		// Nothing pressed and no room: a status word alone.
		add_tick(32'd0, 32'hFFFF_FFFF, 6'd0);
		// Every pedal goes down; too soon to accept, then accepted with room for all.
		add_tick(32'd1, 32'h0000_0000, 6'd32);
		add_tick(32'd4, 32'h0000_0000, 6'd32);
		// Every pedal comes up; the releases leave five at a time, then the rest with a
		// room far larger than what is pending.
		add_tick(32'd10, 32'hFFFF_FFFF, 6'd0);
		add_tick(32'd13, 32'hFFFF_FFFF, 6'd5);
		add_tick(32'd14, 32'hFFFF_FFFF, 6'd63);
		// A bounce on pedal 0 that returns before the debounce time is never accepted.
		add_tick(32'd20, 32'hFFFF_FFFE, 6'd32);
		add_tick(32'd21, 32'hFFFF_FFFF, 6'd32);
		add_tick(32'd30, 32'hFFFF_FFFF, 6'd32);
		// Pedal 0 is accepted as pressed while there is no room, so its note waits.
		add_tick(32'd40, 32'hFFFF_FFFE, 6'd0);
		add_tick(32'd45, 32'hFFFF_FFFE, 6'd0);
		wait_idle();
		// With pedal 0 disabled its level is ignored, but the waiting note still goes out.
		write_reg(REG_ENABLE, 32'hFFFF_FFFE);
		add_tick(32'd50, 32'hFFFF_FFFF, 6'd32);
		wait_idle();
		// Longest debounce across the wrap of the millisecond clock: exactly 255 ms held.
		write_reg(REG_DEBOUNCE, 32'hA5A5_A5FF);
		write_reg(REG_ENABLE, 32'hFFFF_FFFF);
		add_tick(32'hFFFF_FFF0, 32'hFFFF_FFFD, 6'd32);
		add_tick(32'h0000_00EF, 32'hFFFF_FFFD, 6'd32);
		wait_idle();
		// No debounce at all: changes are accepted in the tick that brings them.
		write_reg(REG_DEBOUNCE, 32'd0);
		add_tick(32'h0000_0100, 32'h5555_5555, 6'd32);
		add_tick(32'h0000_0100, 32'hAAAA_AAAA, 6'd16);
		add_tick(32'h0000_0101, 32'hAAAA_AAAA, 6'd20);
		wait_idle();

		// Random part in seven segments, each under its own register settings. The sender
		// pauses at the end of every segment until all owed words have come.
		for (int seg = 0; seg < 7; seg++) begin
			case (seg)
				0: begin
					deb_word = $urandom_range(8);
					en_word  = '1;
					seg_len  = 60;
				end
				1: begin
					deb_word = 32'd255;
					en_word  = $urandom;
					seg_len  = 60;
				end
				2: begin
					deb_word = 32'd0;
					en_word  = '0;
					seg_len  = 20;
				end
				3: begin
					deb_word = $urandom_range(40);
					en_word  = $urandom;
					seg_len  = 60;
					send_idle_pct = 80;
					recv_idle_pct = 6;
				end
				4: begin
					deb_word = 32'd1;
					en_word  = '1;
					seg_len  = 60;
				end
				5: begin
					deb_word = $urandom_range(255);
					en_word  = '1;
					seg_len  = 60;
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
				default: begin
					deb_word = $urandom_range(20);
					en_word  = $urandom | 32'h8000_0001;
					seg_len  = 60;
				end
			endcase
			// The upper bits of the debounce write carry noise that the block must drop.
			deb_word[CFG_DATA_W-1:DEB_W] = (CFG_DATA_W - DEB_W)'($urandom);
			write_reg(REG_DEBOUNCE, deb_word);
			write_reg(REG_ENABLE, en_word);
			queue_random_ticks(seg_len);
			if (seg == 5)
				hold_off_request = 1'b1;
			wait_idle();
		end

		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Ends a run that has hung.
	initial begin
		#(LIMIT_CYCLES * CLK_PERIOD);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
